@@ hw/rtl/hrl_pkg.sv @@
package hrl_pkg;

    localparam int ANGLE_FRAC_BITS = 12;
    localparam int CORDIC_ITERS    = 16;
    localparam int ATAN_LEN        = 24;
    localparam int ITER_W          = $clog2(ATAN_LEN);

    // cordic datapath
    localparam int SCALE_SHIFT = 7;
    localparam int XY_W        = 34;
    localparam int Z_W         = 35;
    localparam int ANG_SHIFT   = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] PI_Q30    = 35'sd3373259368;
    localparam logic signed [Z_W-1:0] ANG_ROUND = Z_W'(1) << (29 - ANGLE_FRAC_BITS);

    // angles and rates inside the limiter
    localparam int ANG_W = 16;
    localparam int LIM_W = 18;
    localparam logic signed [LIM_W-1:0] PI_FX     = LIM_W'((PI_Q30 + ANG_ROUND) >>> ANG_SHIFT);
    localparam logic signed [LIM_W-1:0] TWO_PI_FX = LIM_W'(2 * PI_FX);
    localparam logic [14:0]             TWO_PI_U  = 15'(2 * PI_FX);

    // digit-serial multiplier
    localparam int MUL_W      = 24;
    localparam int MUL_DIGIT  = 4;
    localparam int MUL_STEPS  = MUL_W / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
    localparam int ACC_W      = 50;
    localparam int LEN2_W     = 48;

    // bit-serial divider
    localparam int DIV_NUM_W = 35;
    localparam int DIV_DEN_W = 20;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic [DIV_DEN_W-1:0] ONE_MILLION  = 20'd1000000;
    localparam logic [DIV_DEN_W-1:0] HALF_MILLION = 20'd500000;

    typedef struct packed {
        logic signed [23:0] dir_x;
        logic signed [23:0] dir_y;
        logic signed [23:0] dir_z;
        logic [19:0]        elapsed_time;
    } item_t;

    typedef struct packed {
        logic signed [14:0] heading;
        logic signed [15:0] heading_rate;
    } result_t;

    typedef enum logic [0:0] {
        CFG_MAX_YAW_RATE = 1'b0,
        CFG_MIN_DIR_LEN  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_MUL_L,
        ST_MUL_RT,
        ST_DIV_MC,
        ST_CORDIC,
        ST_DECIDE,
        ST_MUL_Q,
        ST_DIV_Q,
        ST_FINISH
    } state_t;

    // atan(2^-i) in units of 2^-30 rad
    function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic [29:0] v;
        begin
            case (idx)
                5'd0:    v = 30'd843314857;
                5'd1:    v = 30'd497837829;
                5'd2:    v = 30'd263043837;
                5'd3:    v = 30'd133525159;
                5'd4:    v = 30'd67021687;
                5'd5:    v = 30'd33543516;
                5'd6:    v = 30'd16775851;
                5'd7:    v = 30'd8388437;
                5'd8:    v = 30'd4194283;
                5'd9:    v = 30'd2097149;
                5'd10:   v = 30'd1048576;
                5'd11:   v = 30'd524288;
                5'd12:   v = 30'd262144;
                5'd13:   v = 30'd131072;
                5'd14:   v = 30'd65536;
                5'd15:   v = 30'd32768;
                5'd16:   v = 30'd16384;
                5'd17:   v = 30'd8192;
                5'd18:   v = 30'd4096;
                5'd19:   v = 30'd2048;
                5'd20:   v = 30'd1024;
                5'd21:   v = 30'd512;
                5'd22:   v = 30'd256;
                5'd23:   v = 30'd128;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hw/rtl/hrl_mul.sv @@
module hrl_mul
    import hrl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MUL_W-1:0] a,
    input  logic [MUL_W-1:0] b,
    input  logic [ACC_W-1:0] init,
    output logic             done,
    output logic [ACC_W-1:0] product
);

    logic [2*MUL_W-1:0]           a_reg, a_next;
    logic [MUL_W-1:0]             b_reg, b_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [MUL_CNT_W-1:0]         cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [2*MUL_W+MUL_DIGIT-1:0] partial;

    // one 4-bit digit of b per cycle, lsb first
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        partial   = {{MUL_DIGIT{1'b0}}, a_reg} *
                    {{(2*MUL_W){1'b0}}, b_reg[MUL_DIGIT-1:0]};
        if (start)
        begin
            a_next    = {{MUL_W{1'b0}}, a};
            b_next    = b;
            acc_next  = init;
            cnt_next  = MUL_CNT_W'(MUL_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial[ACC_W-1:0];
            a_next   = a_reg << MUL_DIGIT;
            b_next   = b_reg >> MUL_DIGIT;
            cnt_next = cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ hw/rtl/hrl_div.sv @@
module hrl_div
    import hrl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle shifted into num_reg
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ hw/rtl/hrl_cordic.sv @@
module hrl_cordic
    import hrl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [23:0]      x,
    input  logic signed [23:0]      y,
    output logic                    done,
    output logic signed [ANG_W-1:0] angle
);

    logic signed [XY_W-1:0] x_reg, x_next;
    logic signed [XY_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [XY_W-1:0] xs, ys, dx, dy;
    logic signed [Z_W-1:0]  step_ang;
    logic signed [Z_W-1:0]  rnd;
    logic signed [Z_W-1:0]  clamped;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs        = XY_W'(x) <<< SCALE_SHIFT;
        ys        = XY_W'(y) <<< SCALE_SHIFT;
        dx        = x_reg >>> iter_reg;
        dy        = y_reg >>> iter_reg;
        step_ang  = Z_W'(atan_q30(iter_reg));
        if (start)
        begin
            // left half plane: turn by pi first
            if (x < 0)
            begin
                x_next = -xs;
                y_next = -ys;
                z_next = (y >= 0) ? PI_Q30 : -PI_Q30;
            end
            else
            begin
                x_next = xs;
                y_next = ys;
                z_next = '0;
            end
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + step_ang;
            end
            else if (y_reg < 0)
            begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - step_ang;
            end
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(CORDIC_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        rnd = (z_reg + ANG_ROUND) >>> ANG_SHIFT;
        if (rnd > Z_W'(PI_FX))
            clamped = Z_W'(PI_FX);
        else if (rnd < -Z_W'(PI_FX))
            clamped = -Z_W'(PI_FX);
        else
            clamped = rnd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = ANG_W'(clamped);

endmodule

@@ hw/rtl/heading_rate_limiter.sv @@
// Heading rate limiter: one result per accepted request, one request at a time. A request
// passes through five squares and products on the 4-bit-digit multiplier, a 35-step
// bit-serial divide for the step limit, a 16-step cordic for atan2 when the look-ahead
// vector is long enough, and, for an in-limit step with a nonzero elapsed time, one more
// multiply and 35-step divide for the rate.
// A finished result sits in an output register so the next request can be taken while
// it waits. Configuration registers may be written at any time the block is idle.
module heading_rate_limiter
    import hrl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t                  state_reg, state_next;
    item_t                   item_reg, item_next;
    logic [LEN2_W-1:0]       len2_reg, len2_next;
    logic                    long_reg, long_next;
    logic [14:0]             mc_reg, mc_next;
    logic signed [LIM_W-1:0] target_reg, target_next;
    logic signed [LIM_W-1:0] yaw_reg, yaw_next;
    logic signed [LIM_W-1:0] rate_reg, rate_next;
    logic                    rate_neg_reg, rate_neg_next;
    logic signed [ANG_W-1:0] prev_heading_reg, prev_heading_next;
    logic signed [15:0]      prev_rate_reg, prev_rate_next;
    logic [14:0]             max_yaw_rate_reg;
    logic [15:0]             min_len_reg;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    mul_start, mul_done;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [ACC_W-1:0]        mul_init, mul_product;
    logic                    div_start, div_done;
    logic [DIV_NUM_W-1:0]    div_num, div_quot;
    logic [DIV_DEN_W-1:0]    div_den;
    logic                    cor_start, cor_done;
    logic signed [ANG_W-1:0] cor_angle;

    logic signed [LIM_W-1:0] last, mcs, rmax_s, d, d_mag;
    logic signed [LIM_W-1:0] lim_yaw, lim_rate;
    logic                    lim_need_q;
    logic signed [LIM_W-1:0] step, step_mag, yaw_sum, yaw_fin, rate_sum, rate_fin;
    logic [14:0]             q_sat;

    function automatic logic [23:0] mag24(input logic signed [23:0] v);
        logic [23:0] m;
        begin
            m = v[23] ? (~v + 24'd1) : v;
            return m;
        end
    endfunction

    function automatic logic signed [LIM_W-1:0] wrap_pi(input logic signed [LIM_W-1:0] a);
        logic signed [LIM_W-1:0] w;
        begin
            w = a;
            if (w < -PI_FX)
                w = w + TWO_PI_FX;
            if (w > PI_FX)
                w = w - TWO_PI_FX;
            return w;
        end
    endfunction

    hrl_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .init    (mul_init),
        .done    (mul_done),
        .product (mul_product)
    );

    hrl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    hrl_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .x     (item_reg.dir_x),
        .y     (item_reg.dir_y),
        .done  (cor_done),
        .angle (cor_angle)
    );

    // step limiter, valid in the decide state
    always_comb
    begin
        last       = LIM_W'(prev_heading_reg);
        mcs        = signed'({3'b000, mc_reg});
        rmax_s     = signed'({3'b000, max_yaw_rate_reg});
        d          = target_reg - last;
        d_mag      = d[LIM_W-1] ? -d : d;
        lim_need_q = 1'b0;
        lim_yaw    = target_reg;
        lim_rate   = '0;
        if (d > PI_FX)
        begin
            // going the short way round, downward
            if (d - TWO_PI_FX < -mcs)
                lim_yaw = wrap_pi(last - mcs);
            lim_rate = -rmax_s;
        end
        else if (d < -PI_FX)
        begin
            if (d + TWO_PI_FX > mcs)
                lim_yaw = wrap_pi(last + mcs);
            lim_rate = rmax_s;
        end
        else if (d < -mcs)
        begin
            lim_yaw  = wrap_pi(last - mcs);
            lim_rate = -rmax_s;
        end
        else if (d > mcs)
        begin
            lim_yaw  = wrap_pi(last + mcs);
            lim_rate = rmax_s;
        end
        else
        begin
            lim_need_q = 1'b1;
        end
    end

    // smoothing, valid in the finish state
    always_comb
    begin
        step     = yaw_reg - last;
        step_mag = step[LIM_W-1] ? -step : step;
        yaw_sum  = last + yaw_reg;
        yaw_fin  = (step_mag <= mcs) ? (yaw_sum >>> 1) : yaw_reg;
        rate_sum = LIM_W'(prev_rate_reg) + rate_reg;
        rate_fin = rate_sum >>> 1;
        q_sat    = (div_quot > DIV_NUM_W'(max_yaw_rate_reg)) ? max_yaw_rate_reg
                                                              : div_quot[14:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        len2_next         = len2_reg;
        long_next         = long_reg;
        mc_next           = mc_reg;
        target_next       = target_reg;
        yaw_next          = yaw_reg;
        rate_next         = rate_reg;
        rate_neg_next     = rate_neg_reg;
        prev_heading_next = prev_heading_reg;
        prev_rate_next    = prev_rate_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        mul_start         = 1'b0;
        mul_a             = '0;
        mul_b             = '0;
        mul_init          = '0;
        div_start         = 1'b0;
        div_num           = '0;
        div_den           = '0;
        cor_start         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    mul_start  = 1'b1;
                    mul_a      = mag24(item.dir_x);
                    mul_b      = mag24(item.dir_x);
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mag24(item_reg.dir_y);
                    mul_b      = mag24(item_reg.dir_y);
                    mul_init   = mul_product;
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mag24(item_reg.dir_z);
                    mul_b      = mag24(item_reg.dir_z);
                    mul_init   = mul_product;
                    state_next = ST_MUL_Z;
                end
            end
            ST_MUL_Z:
            begin
                if (mul_done)
                begin
                    len2_next  = mul_product[LEN2_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = {8'd0, min_len_reg};
                    mul_b      = {8'd0, min_len_reg};
                    state_next = ST_MUL_L;
                end
            end
            ST_MUL_L:
            begin
                if (mul_done)
                begin
                    long_next  = len2_reg > mul_product[LEN2_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = {9'd0, max_yaw_rate_reg};
                    mul_b      = {4'd0, item_reg.elapsed_time};
                    state_next = ST_MUL_RT;
                end
            end
            ST_MUL_RT:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = mul_product[DIV_NUM_W-1:0] + DIV_NUM_W'(HALF_MILLION);
                    div_den    = ONE_MILLION;
                    state_next = ST_DIV_MC;
                end
            end
            ST_DIV_MC:
            begin
                if (div_done)
                begin
                    mc_next = (div_quot > DIV_NUM_W'(TWO_PI_U)) ? TWO_PI_U : div_quot[14:0];
                    if (long_reg)
                    begin
                        cor_start  = 1'b1;
                        state_next = ST_CORDIC;
                    end
                    else
                    begin
                        target_next = LIM_W'(prev_heading_reg);
                        state_next  = ST_DECIDE;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (cor_done)
                begin
                    target_next = LIM_W'(cor_angle);
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                yaw_next      = lim_yaw;
                rate_next     = lim_rate;
                rate_neg_next = d[LIM_W-1];
                if (lim_need_q && (item_reg.elapsed_time != '0))
                begin
                    // rate = round(|d| * 1e6 / dt): product plus dt/2, then divide
                    mul_start  = 1'b1;
                    mul_a      = {4'd0, ONE_MILLION};
                    mul_b      = MUL_W'(d_mag);
                    mul_init   = ACC_W'(item_reg.elapsed_time >> 1);
                    state_next = ST_MUL_Q;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_Q:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = mul_product[DIV_NUM_W-1:0];
                    div_den    = item_reg.elapsed_time;
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                if (div_done)
                begin
                    rate_next  = rate_neg_reg ? -signed'({3'b000, q_sat})
                                              : signed'({3'b000, q_sat});
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.heading      = yaw_fin[14:0];
                    result_next.heading_rate = rate_fin[15:0];
                    result_valid_next        = 1'b1;
                    prev_heading_next        = yaw_fin[ANG_W-1:0];
                    prev_rate_next           = rate_fin[15:0];
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            prev_heading_reg <= '0;
            prev_rate_reg    <= '0;
            max_yaw_rate_reg <= 15'd12868;
            min_len_reg      <= 16'd102;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            prev_heading_reg <= prev_heading_next;
            prev_rate_reg    <= prev_rate_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_MAX_YAW_RATE: max_yaw_rate_reg <= cfg_data[14:0];
                    CFG_MIN_DIR_LEN:  min_len_reg      <= cfg_data;
                    default:          min_len_reg      <= min_len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        len2_reg     <= len2_next;
        long_reg     <= long_next;
        mc_reg       <= mc_next;
        target_reg   <= target_next;
        yaw_reg      <= yaw_next;
        rate_reg     <= rate_next;
        rate_neg_reg <= rate_neg_next;
        result_reg   <= result_next;
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> state_reg == ST_MUL_X)
        else $error("accepted request did not start the length multiply");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish state");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done) && !(mul_done && cor_done) && !(div_done && cor_done))
        else $error("two arithmetic units finished together");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LIM_W'(prev_heading_reg) >= -PI_FX) && (LIM_W'(prev_heading_reg) <= PI_FX))
        else $error("stored heading outside +-pi");

endmodule

@@ tb/heading_rate_limiter_tb.sv @@
`timescale 1ns / 100ps

module heading_rate_limiter_tb
    import hrl_pkg::*;
();

    localparam longint PI_Q30_REF = 64'sd3373259368;
    localparam longint HALF_TURN  = (PI_Q30_REF + (64'sd1 << 17)) >>> 18;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     DRAIN_WAIT = 200;

    localparam longint ATAN_TAB [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    item_t      item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_MAX_YAW_RATE;
    logic [15:0] cfg_data = '0;

    item_t   pending_requests [$];
    result_t expected_headings [$];

    // shadow of the block's registers and state
    longint rate_limit = 12868;
    longint min_len = 102;
    longint last_heading = 0;
    longint last_rate = 0;

    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_timer = 0;
    int stall_run = 0;

    heading_rate_limiter i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint cordic_atan2(longint x, longint y);
        longint z, dx, dy, r;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 128;
        y = y * 128;
        // left half plane: turn by pi first
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q30_REF : -PI_Q30_REF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0)
            begin
                x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
            end
            else if (y < 0)
            begin
                x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
            end
        end
        r = (z + (64'sd1 << 17)) >>> 18;
        if (r > HALF_TURN) r = HALF_TURN;
        if (r < -HALF_TURN) r = -HALF_TURN;
        return r;
    endfunction

    function automatic longint wrap_angle(longint a);
        if (a < -HALF_TURN) a = a + 2 * HALF_TURN;
        if (a > HALF_TURN) a = a - 2 * HALF_TURN;
        return a;
    endfunction

    function automatic result_t predict_heading(item_t it);
        longint x, y, z, dt, target, mc, d, yaw, rate, step, mag, q;
        result_t r;
        x = it.dir_x;
        y = it.dir_y;
        z = it.dir_z;
        dt = it.elapsed_time;
        target = (x * x + y * y + z * z > min_len * min_len) ? cordic_atan2(x, y)
                                                            : last_heading;
        mc = (rate_limit * dt + 500000) / 1000000;
        if (mc > 2 * HALF_TURN) mc = 2 * HALF_TURN;
        d = target - last_heading;
        if (d > HALF_TURN)
        begin
            yaw = (d - 2 * HALF_TURN < -mc) ? wrap_angle(last_heading - mc) : target;
            rate = -rate_limit;
        end
        else if (d < -HALF_TURN)
        begin
            yaw = (d + 2 * HALF_TURN > mc) ? wrap_angle(last_heading + mc) : target;
            rate = rate_limit;
        end
        else if (d < -mc)
        begin
            yaw = wrap_angle(last_heading - mc);
            rate = -rate_limit;
        end
        else if (d > mc)
        begin
            yaw = wrap_angle(last_heading + mc);
            rate = rate_limit;
        end
        else
        begin
            yaw = target;
            if (dt == 0)
                rate = 0;
            else
            begin
                mag = (d < 0) ? -d : d;
                q = (mag * 1000000 + dt / 2) / dt;
                if (q > rate_limit) q = rate_limit;
                rate = (d < 0) ? -q : q;
            end
        end
        step = yaw - last_heading;
        if (step < 0) step = -step;
        if (step <= mc)
            yaw = (last_heading + yaw) >>> 1;
        rate = (last_rate + rate) >>> 1;
        last_heading = shortint'(yaw);
        last_rate = shortint'(rate);
        r.heading = yaw[14:0];
        r.heading_rate = rate[15:0];
        return r;
    endfunction

    function automatic item_t req(int x, int y, int z, int dt);
        item_t it;
        it.dir_x = 24'(x);
        it.dir_y = 24'(y);
        it.dir_z = 24'(z);
        it.elapsed_time = 20'(dt);
        return it;
    endfunction

    function automatic item_t random_request();
        item_t it;
        int kind, mag;
        kind = $urandom_range(0, 9);
        mag = 1 << $urandom_range(7, 22);
        it = req($urandom_range(0, 2 * mag) - mag, $urandom_range(0, 2 * mag) - mag,
                 $urandom_range(0, mag / 8) - mag / 16, $urandom_range(5000, 30000));
        case (kind)
            6: it = item_t'(92'({$urandom(), $urandom(), $urandom()}));
            7:
            begin
                it.dir_x = 24'($urandom_range(0, 128) - 64);
                it.dir_y = 24'($urandom_range(0, 128) - 64);
                it.dir_z = 24'($urandom_range(0, 128) - 64);
            end
            8: it.elapsed_time = 20'($urandom_range(0, 3));
            9: it.elapsed_time = 20'($urandom());
            default: ;
        endcase
        return it;
    endfunction

    function automatic void queue_request(item_t it);
        pending_requests = {pending_requests, it};
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_YAW_RATE)
            rate_limit = value[14:0];
        else
            min_len = value;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || item_valid || expected_headings.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // request driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (item_valid && !item_stall)
            expected_headings = {expected_headings, predict_heading(item)};
        if (rst_n && (!item_valid || !item_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                item <= pending_requests.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
                end
                else
                    burst_left--;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result stall pattern: none, random, or long runs
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_timer = $urandom_range(200, 3000);
        end
        else
            stall_timer--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= $urandom_range(0, 1);
            default:
            begin
                if (stall_run == 0)
                    stall_run = $urandom_range(1, 300);
                else
                    stall_run--;
                result_stall <= (stall_run > 150);
            end
        endcase
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (result_valid && !result_stall)
        begin
            if (expected_headings.size() == 0)
            begin
                $error("unexpected result: heading %0d rate %0d",
                       result.heading, result.heading_rate);
                errors++;
            end
            else
            begin
                exp_r = expected_headings.pop_front();
                if (result.heading !== exp_r.heading)
                begin
                    $error("heading: expected %0d, actual %0d", exp_r.heading, result.heading);
                    errors++;
                end
                if (result.heading_rate !== exp_r.heading_rate)
                begin
                    $error("heading_rate: expected %0d, actual %0d",
                           exp_r.heading_rate, result.heading_rate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("heading_rate_limiter regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero and short vectors, half-plane turns, wrap
        queue_request(req(0, 0, 0, 10000));
        queue_request(req(102, 0, 0, 10000));
        queue_request(req(103, 0, 0, 10000));
        queue_request(req(0, 0, 103, 10000));
        queue_request(req(-5000, 0, 0, 1048575));
        queue_request(req(-5000, -1, 0, 1048575));
        queue_request(req(-5000, 1, 0, 10000));
        queue_request(req(-5000, 1, 0, 0));
        queue_request(req(-5000, -1, 0, 0));
        queue_request(req(8388607, 8388607, 8388607, 1048575));
        queue_request(req(-8388608, -8388608, -8388608, 0));
        queue_request(req(0, 8388607, 0, 20000));
        queue_request(req(0, -8388608, 0, 20000));
        queue_request(req(-4000, -3, 0, 1000));
        queue_request(req(-4000, 3, 0, 1000));
        queue_request(req(3000, 3000, 0, 1));
        queue_request(req(3000, 3001, 0, 2000000));
        queue_request(req(10, 10, 10, 500));
        for (int i = 0; i < 230; i++)
            queue_request(random_request());
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_MAX_YAW_RATE, 16'd0);
                    write_reg(CFG_MIN_DIR_LEN, 16'd0);
                end
                1:
                begin
                    write_reg(CFG_MAX_YAW_RATE, 16'd25736);
                    write_reg(CFG_MIN_DIR_LEN, 16'hFFFF);
                end
                2:
                begin
                    // bit 15 of the rate register is dropped
                    write_reg(CFG_MAX_YAW_RATE, 16'hFFFF);
                    write_reg(CFG_MIN_DIR_LEN, 16'd1);
                end
                default:
                begin
                    write_reg(CFG_MAX_YAW_RATE, 16'($urandom_range(0, 25736)));
                    write_reg(CFG_MIN_DIR_LEN, 16'($urandom_range(0, 4096)));
                end
            endcase
            for (int i = 0; i < 250; i++)
                queue_request(random_request());
            wait_drained();
        end

        if (errors == 0 && expected_headings.size() == 0)
            $display("heading_rate_limiter regression: pass");
        else
            $display("heading_rate_limiter regression: fail");
        $finish;
    end

endmodule
